@@ rtl/frg_pkg.sv @@
// Shared definitions for the fraction reduce GCD block.
// Holds the default data width, sequencer state codes and the divider status type.
// No dependencies.
package frg_pkg;

   // Default field width of numerator, denominator and divisor
   localparam int DATA_WIDTH = 32;

   // Sequencer state codes
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LOOP = 3'd1;
   localparam logic [2:0] ST_REM  = 3'd2;
   localparam logic [2:0] ST_DIVN = 3'd3;
   localparam logic [2:0] ST_DIVD = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   // Status of the serial divider toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

@@ rtl/fraction_reduce_gcd.sv @@
// Top level of the fraction reduce GCD block: Euclid sequencer and output register.
// Uses frg_divider for every remainder and exact quotient; depends on frg_pkg.
//
//   channel  direction  tdata (low bit up)                              tuser
//   req      in         numerator_in, denominator_in                    -
//   rsp      out        numerator_out, denominator_out, common_divisor  zero_error
//
// Every Euclid step and both exact quotients run in turn through the shared serial divider,
// which yields one quotient bit per cycle; a transaction runs k Euclid steps (k up to
// about 46 at 32 bits) and then the two exact divisions, or none when both inputs are
// zero. A new request is taken only after the result has left the sequencer.
// Reset: synchronous, active high; clears sequencer, divider control and rsp_tvalid.
// Stalls: a finished result waits in the output register while the next request
// is taken; the sequencer holds in its done state only if that register is still full.
module fraction_reduce_gcd #(
   parameter int DATA_WIDTH = frg_pkg::DATA_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [((2 * DATA_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,
                                               // numerator_in, denominator_in
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [((3 * DATA_WIDTH + 7) / 8) * 8 - 1:0] rsp_tdata,
                                               // numerator_out, denominator_out,
                                               // common_divisor
   output logic                   rsp_tuser    // zero_error
);

   localparam int REQ_W = ((2 * DATA_WIDTH + 7) / 8) * 8;
   localparam int RSP_W = ((3 * DATA_WIDTH + 7) / 8) * 8;
   localparam int W     = DATA_WIDTH;

   logic [2:0]   state_ff, state_in;
   logic         sn_ff, sn_in, sd_ff, sd_in, sa_ff, sa_in, sb_ff, sb_in;
   logic [W-1:0] mn_ff, mn_in, md_ff, md_in, ma_ff, ma_in, mb_ff, mb_in;
   logic [W-1:0] qn_ff, qn_in, qd_ff, qd_in;
   logic         zerr_ff, zerr_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;
   logic         rsp_user_ff, rsp_user_in;

   logic [W-1:0] num_raw, den_raw;
   logic [W-1:0] div_a, div_b, div_quo, div_rem;
   logic         div_start;
   frg_pkg::div_status_type div_status;
   logic [W-1:0] out_num, out_den, out_gcd;
   logic         out_free;

   frg_divider #(.DATA_WIDTH(DATA_WIDTH)) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_a),
      .divisor   (div_b),
      .quotient  (div_quo),
      .remainder (div_rem),
      .status    (div_status)
   );

   assign num_raw  = req_tdata[W-1:0];
   assign den_raw  = req_tdata[2*W-1:W];
   assign out_free = ~rsp_valid_ff | rsp_tready;

   // Apply signs to the reduced magnitudes, wrapping to the field width
   always_comb begin
      out_num = (sn_ff ^ sa_ff) ? (W'(0) - qn_ff) : qn_ff;
      out_den = (sd_ff ^ sa_ff) ? (W'(0) - qd_ff) : qd_ff;
      out_gcd = sa_ff ? (W'(0) - ma_ff) : ma_ff;
   end

   // Euclid sequencer around the shared divider
   always_comb begin
      state_in     = state_ff;
      sn_in        = sn_ff;
      sd_in        = sd_ff;
      sa_in        = sa_ff;
      sb_in        = sb_ff;
      mn_in        = mn_ff;
      md_in        = md_ff;
      ma_in        = ma_ff;
      mb_in        = mb_ff;
      qn_in        = qn_ff;
      qd_in        = qd_ff;
      zerr_in      = zerr_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      div_start    = 1'b0;
      div_a        = ma_ff;
      div_b        = mb_ff;
      case (state_ff)
         frg_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               sn_in    = num_raw[W-1];
               sd_in    = den_raw[W-1];
               mn_in    = num_raw[W-1] ? (W'(0) - num_raw) : num_raw;
               md_in    = den_raw[W-1] ? (W'(0) - den_raw) : den_raw;
               sa_in    = num_raw[W-1];
               sb_in    = den_raw[W-1];
               ma_in    = num_raw[W-1] ? (W'(0) - num_raw) : num_raw;
               mb_in    = den_raw[W-1] ? (W'(0) - den_raw) : den_raw;
               state_in = frg_pkg::ST_LOOP;
            end
         end
         frg_pkg::ST_LOOP: begin
            if (mb_ff == '0) begin
               if (ma_ff == '0) begin
                  zerr_in  = 1'b1;
                  state_in = frg_pkg::ST_DONE;
               end else begin
                  zerr_in   = 1'b0;
                  div_start = 1'b1;
                  div_a     = mn_ff;
                  div_b     = ma_ff;
                  state_in  = frg_pkg::ST_DIVN;
               end
            end else begin
               div_start = 1'b1;
               state_in  = frg_pkg::ST_REM;
            end
         end
         frg_pkg::ST_REM: begin
            // Swap: divisor becomes dividend, remainder keeps old dividend sign
            if (div_status.done) begin
               sa_in    = sb_ff;
               ma_in    = mb_ff;
               sb_in    = sa_ff;
               mb_in    = div_rem;
               state_in = frg_pkg::ST_LOOP;
            end
         end
         frg_pkg::ST_DIVN: begin
            if (div_status.done) begin
               qn_in     = div_quo;
               div_start = 1'b1;
               div_a     = md_ff;
               div_b     = ma_ff;
               state_in  = frg_pkg::ST_DIVD;
            end
         end
         frg_pkg::ST_DIVD: begin
            if (div_status.done) begin
               qd_in    = div_quo;
               state_in = frg_pkg::ST_DONE;
            end
         end
         frg_pkg::ST_DONE: begin
            // Hand the result to the output register once it is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = zerr_ff;
               if (zerr_ff) begin
                  rsp_data_in = '0;
               end else begin
                  rsp_data_in = RSP_W'({out_gcd, out_den, out_num});
               end
               state_in = frg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = frg_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= frg_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sn_ff       <= sn_in;
      sd_ff       <= sd_in;
      sa_ff       <= sa_in;
      sb_ff       <= sb_in;
      mn_ff       <= mn_in;
      md_ff       <= md_in;
      ma_ff       <= ma_in;
      mb_ff       <= mb_in;
      qn_ff       <= qn_in;
      qd_ff       <= qd_in;
      zerr_ff     <= zerr_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign req_tready = (state_ff == frg_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef SYNTH
   // Exact divisions only start with a nonzero divisor
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == frg_pkg::ST_DIVN || state_ff == frg_pkg::ST_DIVD) |-> ma_ff != '0)
      else $error("exact division with zero divisor");

   // A zero error result carries all-zero fields
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_user_ff) |-> rsp_data_ff == '0)
      else $error("zero error result with nonzero data");

   // Divider completes only while the sequencer waits for it
   a_done_state: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == frg_pkg::ST_REM || state_ff == frg_pkg::ST_DIVN ||
                           state_ff == frg_pkg::ST_DIVD))
      else $error("divider done outside a wait state");

   // Divider is never restarted while busy
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      div_status.busy |-> !div_start)
      else $error("divider restarted while busy");
`endif

endmodule

@@ rtl/frg_divider.sv @@
// Radix-2 restoring divider for unsigned magnitudes, one quotient bit per cycle.
// Dividend shifts out of a register one bit a cycle into the partial remainder.
// Depends on frg_pkg.
module frg_divider #(
   parameter int DATA_WIDTH = frg_pkg::DATA_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [DATA_WIDTH-1:0]  dividend,
   input  logic [DATA_WIDTH-1:0]  divisor,
   output logic [DATA_WIDTH-1:0]  quotient,
   output logic [DATA_WIDTH-1:0]  remainder,
   output frg_pkg::div_status_type status
);

   localparam int CNT_W = $clog2(DATA_WIDTH + 1);

   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] quo_ff, quo_in;
   logic [DATA_WIDTH-1:0] dsr_ff, dsr_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DATA_WIDTH:0]   part;
   logic [DATA_WIDTH:0]   diff;
   logic                  fits;

   // Trial subtract of the divisor from the shifted partial remainder
   always_comb begin
      part = {rem_ff, quo_ff[DATA_WIDTH-1]};
      diff = part - {1'b0, dsr_ff};
      fits = ~diff[DATA_WIDTH];
   end

   // Load on start, then shift one quotient bit per cycle
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
         cnt_in  = CNT_W'(DATA_WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DATA_WIDTH-1:0] : part[DATA_WIDTH-1:0];
         quo_in = {quo_ff[DATA_WIDTH-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign quotient    = quo_ff;
   assign remainder   = rem_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule
